### sv/lcs_pkg.sv
// lcs_pkg: shared types and constants for the least-connections selector
// item structs, update command, controller states, register reset value
// no dependencies
package lcs_pkg;

  // configuration register
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] HOST_COUNT_RESET = 5'd1;

  // action codes
  localparam logic ACT_SELECT  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // input item
  typedef struct packed {
    logic       action;
    logic [3:0] release_index;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [3:0] chosen_index;
    logic       error;
  } out_item_t;

  // counter update command broadcast to all cells
  typedef struct packed {
    logic inc;
    logic dec;
  } upd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_SEL_INJ,
    ST_SEL_WAIT
  } state_t;

endpackage

### sv/lcs_cell.sv
// lcs_cell: one host's open-connection counter plus one stage of the
// minimum-search chain; the search token moves one cell per cycle
// depends on lcs_pkg
module lcs_cell #(
  parameter int IDX  = 0,
  parameter int CW   = 16,
  parameter int IDXW = 4,
  parameter int HW   = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [HW-1:0]    n_i,
  input  lcs_pkg::upd_t    upd_i,
  input  logic [IDXW-1:0]  upd_idx_i,
  input  logic             c_valid_i,
  input  logic             c_have_i,
  input  logic [CW-1:0]    c_cnt_i,
  input  logic [IDXW-1:0]  c_idx_i,
  output logic             c_valid_o,
  output logic             c_have_o,
  output logic [CW-1:0]    c_cnt_o,
  output logic [IDXW-1:0]  c_idx_o,
  output logic             is_zero_o
);
  import lcs_pkg::*;

  logic [CW-1:0]   count_r, count_nxt;
  logic            valid_r, have_r;
  logic [CW-1:0]   best_cnt_r, best_cnt_nxt;
  logic [IDXW-1:0] best_idx_r, best_idx_nxt;
  logic            in_use, hit, take;

  assign in_use = (HW'(IDX) < n_i);
  assign hit    = (upd_idx_i == IDXW'(IDX));

  // saturating counter update
  always_comb begin
    count_nxt = count_r;
    if (hit && upd_i.inc && (count_r != '1)) begin
      count_nxt = count_r + CW'(1);
    end else if (hit && upd_i.dec && (count_r != '0)) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // keep the running minimum; strict compare keeps the lower index on ties
  assign take = in_use && (!c_have_i || (count_r < c_cnt_i));

  always_comb begin
    best_cnt_nxt = c_cnt_i;
    best_idx_nxt = c_idx_i;
    if (take) begin
      best_cnt_nxt = count_r;
      best_idx_nxt = IDXW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= c_valid_i;
      have_r  <= c_have_i | in_use;
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    best_cnt_r <= best_cnt_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign c_valid_o = valid_r;
  assign c_have_o  = have_r;
  assign c_cnt_o   = best_cnt_r;
  assign c_idx_o   = best_idx_r;
  assign is_zero_o = (count_r == '0);

endmodule

### sv/least_connections_selector_top.sv
// Least-connections selector: a release is busy in ST_REL; its result is then registered onto out_strobe.
// A select is busy in ST_SEL_INJ and ST_SEL_WAIT until its result leaves the last cell:
// a search token walks the row of counter cells one cell per cycle.
// A new item can be accepted in the cycle its predecessor's result is on the outputs.
// Synchronous active-low reset clears all counters and sets host_count to 1.
// Results are shown for one cycle on out_strobe; the receiver cannot stall.
module least_connections_selector_top #(
  parameter int MAX_HOSTS   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  lcs_pkg::in_item_t                 in_item,
  output logic                              out_strobe,
  output lcs_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [lcs_pkg::CFG_W-1:0]         cfg_wdata
);
  import lcs_pkg::*;

  localparam int IDXW = $clog2(MAX_HOSTS);
  localparam int HW   = $clog2(MAX_HOSTS + 1);
  localparam int NW   = (HW > CFG_W) ? HW : CFG_W;
  localparam int CMPW = (HW > 4) ? HW : 4;

  logic [CFG_W-1:0] host_count_r;
  logic [NW-1:0]    host_ext;
  logic [HW-1:0]    n_use;

  state_t    state_r, state_nxt;
  in_item_t  cmd_r;
  logic      accept;
  logic      out_strobe_r, out_strobe_nxt;
  out_item_t out_r, out_nxt;

  logic            inject;
  upd_t            upd;
  logic [IDXW-1:0] upd_idx;
  logic            rel_err;

  // search chain between cells
  logic [MAX_HOSTS:0]                c_valid;
  logic [MAX_HOSTS:0]                c_have;
  logic [MAX_HOSTS:0][COUNT_WIDTH-1:0] c_cnt;
  logic [MAX_HOSTS:0][IDXW-1:0]      c_idx;
  logic [MAX_HOSTS-1:0]              zero_v;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_count_r <= HOST_COUNT_RESET;
    end else if (cfg_we) begin
      host_count_r <= cfg_wdata;
    end
  end

  // hosts in use, clamped to 1..MAX_HOSTS
  always_comb begin
    host_ext = NW'(host_count_r);
    if (host_ext == '0) begin
      n_use = HW'(1);
    end else if (host_ext > NW'(MAX_HOSTS)) begin
      n_use = HW'(MAX_HOSTS);
    end else begin
      n_use = HW'(host_ext);
    end
  end

  // head of the chain
  assign c_valid[0] = inject;
  assign c_have[0]  = 1'b0;
  assign c_cnt[0]   = '0;
  assign c_idx[0]   = '0;

  for (genvar g = 0; g < MAX_HOSTS; g++) begin : g_cell
    lcs_cell #(
      .IDX  (g),
      .CW   (COUNT_WIDTH),
      .IDXW (IDXW),
      .HW   (HW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .n_i       (n_use),
      .upd_i     (upd),
      .upd_idx_i (upd_idx),
      .c_valid_i (c_valid[g]),
      .c_have_i  (c_have[g]),
      .c_cnt_i   (c_cnt[g]),
      .c_idx_i   (c_idx[g]),
      .c_valid_o (c_valid[g+1]),
      .c_have_o  (c_have[g+1]),
      .c_cnt_o   (c_cnt[g+1]),
      .c_idx_o   (c_idx[g+1]),
      .is_zero_o (zero_v[g])
    );
  end

  assign accept = start && !busy;

  // release check: bad index or empty counter
  always_comb begin
    priority if (CMPW'(cmd_r.release_index) >= CMPW'(n_use)) begin
      rel_err = 1'b1;
    end else begin
      rel_err = zero_v[IDXW'(cmd_r.release_index)];
    end
  end

  // controller: next state and outputs
  always_comb begin
    state_nxt      = state_r;
    busy           = 1'b1;
    inject         = 1'b0;
    upd            = '0;
    upd_idx        = '0;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = (in_item.action == ACT_RELEASE) ? ST_REL : ST_SEL_INJ;
        end
      end
      ST_REL: begin
        upd.dec              = !rel_err;
        upd_idx              = IDXW'(cmd_r.release_index);
        out_strobe_nxt       = 1'b1;
        out_nxt.chosen_index = '0;
        out_nxt.error        = rel_err;
        state_nxt            = ST_IDLE;
      end
      ST_SEL_INJ: begin
        inject    = 1'b1;
        state_nxt = ST_SEL_WAIT;
      end
      ST_SEL_WAIT: begin
        if (c_valid[MAX_HOSTS]) begin
          upd.inc              = 1'b1;
          upd_idx              = c_idx[MAX_HOSTS];
          out_strobe_nxt       = 1'b1;
          out_nxt.chosen_index = 4'(c_idx[MAX_HOSTS]);
          out_nxt.error        = 1'b0;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and strobe registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  // an accepted item always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  // only one search token travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(c_valid[MAX_HOSTS:1]))
    else $error("more than one search token in the chain");

  // the token leaves the chain only while the controller waits for it
  a_token_wait: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid[MAX_HOSTS] |-> (state_r == ST_SEL_WAIT))
    else $error("search result arrived outside the wait state");

  // an error result comes only from a release
  a_err_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.error) |-> $past(state_r == ST_REL))
    else $error("error flag on a select result");

endmodule

### bench/tb_least_connections_selector_top.sv
`timescale 1ns / 100ps
// Self-checking bench for least_connections_selector_top: directed and random select and
// release items, host count writes and clamping. Depends on lcs_pkg and the top.
module tb_least_connections_selector_top;
  import lcs_pkg::*;

  localparam int NUM_HOSTS = 16;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int RANDOM_ITEMS = 950;
  localparam int WATCHDOG_LIMIT = 1000;

  // per-host open-connection load, host count and the expected result queue
  class host_load_tracker;
    logic [COUNT_W-1:0] open_load [NUM_HOSTS];
    logic [CFG_W-1:0] host_count_reg;
    out_item_t expected_results[$];
    int mismatches;

    function new();
      foreach (open_load[i]) open_load[i] = '0;
      host_count_reg = HOST_COUNT_RESET;
      mismatches = 0;
    endfunction

    function void set_host_count(logic [CFG_W-1:0] v);
      host_count_reg = v;
    endfunction

    // zero counts as one host, anything above the row as the full row
    function int active_hosts();
      if (host_count_reg == 0) return 1;
      if (host_count_reg > NUM_HOSTS) return NUM_HOSTS;
      return int'(host_count_reg);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // apply one accepted item to the load table and queue its result
    function void note_item(in_item_t it);
      out_item_t exp;
      int n;
      int best;
      n = active_hosts();
      exp = '0;
      if (it.action == ACT_SELECT) begin
        best = 0;
        for (int h = 1; h < n; h++) begin
          if (open_load[h] < open_load[best]) best = h;
        end
        if (open_load[best] != COUNT_MAX) open_load[best] = open_load[best] + 1'b1;
        exp.chosen_index = 4'(best);
      end else begin
        if (int'(it.release_index) >= n || open_load[it.release_index] == 0)
          exp.error = 1'b1;
        else
          open_load[it.release_index] = open_load[it.release_index] - 1'b1;
      end
      expected_results.push_back(exp);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: chosen %0d error %0b",
                                  got.chosen_index, got.error));
        return;
      end
      exp = expected_results.pop_front();
      if (got.chosen_index !== exp.chosen_index)
        report_mismatch($sformatf("chosen_index %0d, expected %0d",
                                  got.chosen_index, exp.chosen_index));
      if (got.error !== exp.error)
        report_mismatch($sformatf("error %0b, expected %0b", got.error, exp.error));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  host_load_tracker tracker = new();
  int sender_idle_pct = 0;
  int quiet_cycles = 0;

  least_connections_selector_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_strobe) tracker.check_result(out_item);
  end

  // cycles with no item accepted and no result shown
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("least_connections_selector_top test failed");
    $finish;
  end

  // present one item, holding start until the block takes it
  task automatic send_item(input logic act, input logic [3:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_item.action = act;
    in_item.release_index = idx;
    start = 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_item(in_item);
  endtask

  // stop sending until every pending result has come back
  task automatic wait_drain();
    @(negedge clk);
    start = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic write_host_count(input logic [CFG_W-1:0] v);
    wait_drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    tracker.set_host_count(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly selects and releases of loaded hosts, some arbitrary releases
  task automatic send_random();
    int n;
    int loaded[$];
    logic act;
    logic [3:0] idx;
    n = tracker.active_hosts();
    act = ($urandom_range(99) < 55) ? ACT_SELECT : ACT_RELEASE;
    idx = 4'($urandom_range(15));
    if (act == ACT_RELEASE && $urandom_range(99) < 75) begin
      for (int h = 0; h < n; h++) begin
        if (tracker.open_load[h] != 0) loaded.push_back(h);
      end
      if (loaded.size() > 0) idx = 4'(loaded[$urandom_range(loaded.size() - 1)]);
    end
    send_item(act, idx);
  endtask

  function automatic logic [CFG_W-1:0] random_host_count();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return CFG_W'($urandom_range(31, 17));
    if (pick == 2) return CFG_W'(NUM_HOSTS);
    return CFG_W'($urandom_range(NUM_HOSTS, 1));
  endfunction

  initial begin
    int phase_idle [3];
    phase_idle[0] = 23;
    phase_idle[1] = 53;
    phase_idle[2] = 0;

    // reset
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // one host after reset: selects go to host 0, releases beyond it fail
    send_item(ACT_SELECT, 4'hf);
    send_item(ACT_SELECT, 4'h0);
    send_item(ACT_RELEASE, 4'h0);
    send_item(ACT_RELEASE, 4'h1);
    send_item(ACT_RELEASE, 4'hf);

    // full row: ties go to the lowest index
    write_host_count(5'd16);
    send_item(ACT_SELECT, 4'h0);
    send_item(ACT_SELECT, 4'h5);
    send_item(ACT_SELECT, 4'ha);
    send_item(ACT_RELEASE, 4'hf);
    send_item(ACT_RELEASE, 4'h2);
    send_item(ACT_RELEASE, 4'h2);

    // zero host count acts as one host
    write_host_count(5'd0);
    send_item(ACT_SELECT, 4'h3);
    send_item(ACT_RELEASE, 4'h1);

    // host count above the row acts as the full row
    write_host_count(5'd31);
    send_item(ACT_SELECT, 4'h0);
    send_item(ACT_SELECT, 4'h0);
    send_item(ACT_RELEASE, 4'hf);
    send_item(ACT_RELEASE, 4'h3);

    // lowered host count: a release beyond the new range fails
    write_host_count(5'd2);
    send_item(ACT_RELEASE, 4'h3);
    send_item(ACT_SELECT, 4'h7);

    // random items in three idling phases
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = phase_idle[p];
      write_host_count(random_host_count());
      for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
        if ($urandom_range(59) == 0) write_host_count(random_host_count());
        if ($urandom_range(39) == 0) wait_drain();
        send_random();
      end
    end

    // single host loaded, released and refilled, then three hosts
    sender_idle_pct = 0;
    write_host_count(5'd1);
    send_item(ACT_SELECT, 4'h9);
    send_item(ACT_RELEASE, 4'h0);
    send_item(ACT_SELECT, 4'h0);
    send_item(ACT_SELECT, 4'h0);
    write_host_count(5'd3);
    send_item(ACT_SELECT, 4'h0);
    send_item(ACT_RELEASE, 4'h0);

    // let the last result and any stray strobe show up
    wait_drain();
    repeat (NUM_HOSTS + 4) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("least_connections_selector_top test passed");
    else
      $display("least_connections_selector_top test failed");
    $finish;
  end

endmodule
